// ===== rtl/core/htp_pkg.sv =====
// Shared types and constants for the heading turn PID block.
`default_nettype none

package htp_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_P        = 3'd0,
      CSR_GAIN_I        = 3'd1,
      CSR_GAIN_D        = 3'd2,
      CSR_INTEGRAL_ZONE = 3'd3,
      CSR_SETTLE_BAND   = 3'd4,
      CSR_MAX_DRIVE     = 3'd5,
      CSR_TIMEOUT_TICKS = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_RUNNING = 2'd0,
      STATUS_SETTLED = 2'd1,
      STATUS_TIMEOUT = 2'd2,
      STATUS_IDLE    = 2'd3
   } status_type;

   localparam logic FUNC_START  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // register reset values
   localparam logic [15:0] GAIN_P_RESET        = 16'd275;
   localparam logic [15:0] GAIN_I_RESET        = 16'd0;
   localparam logic [15:0] GAIN_D_RESET        = 16'd10;
   localparam logic [14:0] INTEGRAL_ZONE_RESET = 15'd1000;
   localparam logic [14:0] SETTLE_BAND_RESET   = 15'd50;
   localparam logic [13:0] MAX_DRIVE_RESET     = 14'd12000;
   localparam logic [15:0] TIMEOUT_RESET       = 16'd1200;

   // heading wrap, centidegrees
   localparam logic [15:0] FULL_TURN = 16'd36000;
   localparam logic [14:0] HALF_TURN = 15'd18000;
   // floor(2^34 / 36000): quotient low by at most one for 25-bit inputs
   localparam logic [18:0] RECIP_FULL_TURN = 19'd477218;
   localparam int unsigned RECIP_FULL_SHIFT = 34;

   // drive scale: ceil(2^28 / 100) is exact for inputs below 2^21
   localparam logic [6:0]  GAIN_SCALE        = 7'd100;
   localparam logic [21:0] RECIP_SCALE       = 22'd2684355;
   localparam int unsigned RECIP_SCALE_SHIFT = 28;

   localparam logic signed [23:0] SUM_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] SUM_MIN = -24'sh800000;

   // terms handed from the state stage to the drive back end
   typedef struct packed {
      logic               zero;
      status_type         status;
      logic signed [15:0] err;
      logic signed [23:0] sum;
      logic signed [16:0] delta;
   } term_type;

endpackage

`default_nettype wire

// ===== rtl/core/htp_drive.sv =====
// Drive back end: P+I+D products, scale by 1/100 toward zero and clamp.
`default_nettype none

module htp_drive
   import htp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire term_type           in_term,
   input  wire logic [15:0]        gain_p,
   input  wire logic [15:0]        gain_i,
   input  wire logic [15:0]        gain_d,
   input  wire logic [13:0]        max_drive,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic signed [14:0]      out_drive,
   output status_type              out_status
);

   // stage valids and readies
   logic p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff, o_v_ff;
   logic r1, r2, r3, r4, ro;

   // clamp limit scaled by 100: |total| at or above it clamps
   logic [20:0] lim_ff, lim_in;

   term_type p1_ff;

   logic               p2_zero_ff;
   status_type         p2_status_ff;
   logic signed [32:0] p2_pe_ff, pe_in;
   logic signed [40:0] p2_ps_ff, ps_in;
   logic signed [33:0] p2_pd_ff, pd_in;

   logic               p3_zero_ff;
   status_type         p3_status_ff;
   logic signed [41:0] p3_total_ff, total_in;

   logic               p4_zero_ff, p4_neg_ff, p4_big_ff;
   status_type         p4_status_ff;
   logic [20:0]        p4_x_ff;
   logic signed [41:0] total_neg;
   logic [41:0]        abs_total;
   logic               big_in;

   logic [42:0]        quot_prod;
   logic [13:0]        mag;
   logic signed [14:0] mag_s;
   logic signed [14:0] drive_in;
   logic signed [14:0] drive_ff;
   status_type         status_ff;

   assign ro       = !o_v_ff || out_ready;
   assign r4       = !p4_v_ff || ro;
   assign r3       = !p3_v_ff || r4;
   assign r2       = !p2_v_ff || r3;
   assign r1       = !p1_v_ff || r2;
   assign in_ready = r1;

   assign lim_in = (21'(max_drive) + 21'd1) * 21'(GAIN_SCALE);

   assign pe_in = 33'(p1_ff.err) * 33'(signed'({1'b0, gain_p}));
   assign ps_in = 41'(p1_ff.sum) * 41'(signed'({1'b0, gain_i}));
   assign pd_in = 34'(p1_ff.delta) * 34'(signed'({1'b0, gain_d}));

   assign total_in = 42'(p2_pe_ff) + 42'(p2_ps_ff) + 42'(p2_pd_ff);

   assign total_neg = -p3_total_ff;
   assign abs_total = p3_total_ff[41] ? total_neg : p3_total_ff;
   assign big_in    = abs_total >= 42'(lim_ff);

   assign quot_prod = 43'(p4_x_ff) * 43'(RECIP_SCALE);
   assign mag       = p4_big_ff ? max_drive
                                : quot_prod[RECIP_SCALE_SHIFT+13:RECIP_SCALE_SHIFT];
   assign mag_s     = signed'({1'b0, mag});
   assign drive_in  = p4_zero_ff ? 15'sd0 : (p4_neg_ff ? -mag_s : mag_s);

   always_ff @(posedge clock) begin
      lim_ff <= lim_in;
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
         o_v_ff  <= 1'b0;
      end else begin
         if (r1) p1_v_ff <= in_valid;
         if (r2) p2_v_ff <= p1_v_ff;
         if (r3) p3_v_ff <= p2_v_ff;
         if (r4) p4_v_ff <= p3_v_ff;
         if (ro) o_v_ff  <= p4_v_ff;
      end
      if (r1 && in_valid) p1_ff <= in_term;
      if (r2 && p1_v_ff) begin
         p2_zero_ff   <= p1_ff.zero;
         p2_status_ff <= p1_ff.status;
         p2_pe_ff     <= pe_in;
         p2_ps_ff     <= ps_in;
         p2_pd_ff     <= pd_in;
      end
      if (r3 && p2_v_ff) begin
         p3_zero_ff   <= p2_zero_ff;
         p3_status_ff <= p2_status_ff;
         p3_total_ff  <= total_in;
      end
      if (r4 && p3_v_ff) begin
         p4_zero_ff   <= p3_zero_ff;
         p4_status_ff <= p3_status_ff;
         p4_neg_ff    <= p3_total_ff[41];
         p4_big_ff    <= big_in;
         p4_x_ff      <= abs_total[20:0];
      end
      if (ro && p4_v_ff) begin
         drive_ff  <= drive_in;
         status_ff <= p4_status_ff;
      end
   end

   assign out_valid  = o_v_ff;
   assign out_drive  = drive_ff;
   assign out_status = status_ff;

endmodule

`default_nettype wire

// ===== rtl/core/heading_turn_pid.sv =====
// Top level of the heading turn PID: stream ports, registers, wrap and state stages.
`default_nettype none

// Heading turn controller. A start transfer (tuser 0) latches the target as
// heading plus turn_amount and clears integral, last error and tick count; a
// sample transfer (tuser 1) yields the drive for the current heading. Every
// request transfer gives exactly one response transfer, in order. The block
// is a ten-register pipeline: it takes one transfer per clock unless back
// pressure from the response side holds it. Each stage holds its item only
// while the stage behind it is full, so bubbles close up under back pressure
// and new requests keep flowing in until every stage is full. The integral,
// last error and tick count live in a single stage, so back-to-back samples
// see each other's updates. Registers are written through csr_we/csr_index/
// csr_wdata; the user must write them only while no item is in flight, and
// the block itself does not enforce it; index 7 is ignored.

module heading_turn_pid
   import htp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request side
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [47:0]            req_tdata,  // heading[23:0], turn_amount[43:24], zero
   input  wire logic                   req_tuser,  // func
   // response side
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [15:0]                 rsp_tdata,  // drive[14:0], zero
   output logic [1:0]                  rsp_tuser,  // status
   // register writes
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // ---------------- configuration registers ----------------
   logic [15:0] gain_p_ff, gain_i_ff, gain_d_ff, timeout_ff;
   logic [14:0] zone_ff, settle_ff;
   logic [13:0] max_drive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= GAIN_P_RESET;
         gain_i_ff    <= GAIN_I_RESET;
         gain_d_ff    <= GAIN_D_RESET;
         zone_ff      <= INTEGRAL_ZONE_RESET;
         settle_ff    <= SETTLE_BAND_RESET;
         max_drive_ff <= MAX_DRIVE_RESET;
         timeout_ff   <= TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_P:        gain_p_ff    <= csr_wdata;
            CSR_GAIN_I:        gain_i_ff    <= csr_wdata;
            CSR_GAIN_D:        gain_d_ff    <= csr_wdata;
            CSR_INTEGRAL_ZONE: zone_ff      <= csr_wdata[14:0];
            CSR_SETTLE_BAND:   settle_ff    <= csr_wdata[14:0];
            CSR_MAX_DRIVE:     max_drive_ff <= csr_wdata[13:0];
            CSR_TIMEOUT_TICKS: timeout_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- pipeline handshake ----------------
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic r0, r1, r2, r3, r4, r5;
   logic fire4;

   assign r4         = !v4_ff || r5;
   assign r3         = !v3_ff || r4;
   assign r2         = !v2_ff || r3;
   assign r1         = !v1_ff || r2;
   assign r0         = !v0_ff || r1;
   assign req_tready = r0;
   assign fire4      = v4_ff && r5;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (r0) v0_ff <= req_tvalid;
         if (r1) v1_ff <= v0_ff;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
      end
   end

   // ---------------- stage 0: input register, target, raw error ----------------
   logic               s0_func_ff;
   logic signed [23:0] s0_heading_ff;
   logic signed [19:0] s0_turn_ff;
   logic signed [24:0] target_ff, target_in;
   logic signed [25:0] diff, diff_neg;
   logic [24:0]        abs_in;

   always_ff @(posedge clock) begin
      if (r0 && req_tvalid) begin
         s0_func_ff    <= req_tuser;
         s0_heading_ff <= req_tdata[23:0];
         s0_turn_ff    <= req_tdata[43:24];
      end
   end

   assign target_in = 25'(s0_heading_ff) + 25'(s0_turn_ff);
   // target moves only when a start leaves this stage, so later samples see it
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (v0_ff && r1 && s0_func_ff == FUNC_START) begin
         target_ff <= target_in;
      end
   end

   assign diff     = 26'(target_ff) - 26'(s0_heading_ff);
   assign diff_neg = -diff;
   assign abs_in   = diff[25] ? diff_neg[24:0] : diff[24:0];

   // ---------------- stage 1: quotient by a full turn ----------------
   logic        s1_func_ff, s1_neg_ff;
   logic [24:0] s1_abs_ff;
   logic [43:0] quot_prod;

   always_ff @(posedge clock) begin
      if (r1 && v0_ff) begin
         s1_func_ff <= s0_func_ff;
         s1_neg_ff  <= diff[25];
         s1_abs_ff  <= abs_in;
      end
   end

   assign quot_prod = 44'(s1_abs_ff) * 44'(RECIP_FULL_TURN);

   // ---------------- stage 2: remainder with one correction ----------------
   logic        s2_func_ff, s2_neg_ff;
   logic [24:0] s2_abs_ff;
   logic [8:0]  s2_quot_ff;
   logic [24:0] quot_turns, rem_raw;
   logic [15:0] rem_in;

   always_ff @(posedge clock) begin
      if (r2 && v1_ff) begin
         s2_func_ff <= s1_func_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_abs_ff  <= s1_abs_ff;
         s2_quot_ff <= quot_prod[RECIP_FULL_SHIFT+8:RECIP_FULL_SHIFT];
      end
   end

   assign quot_turns = 25'(s2_quot_ff) * 25'(FULL_TURN);
   assign rem_raw    = s2_abs_ff - quot_turns;
   assign rem_in     = (rem_raw >= 25'(FULL_TURN)) ? 16'(rem_raw - 25'(FULL_TURN))
                                                   : rem_raw[15:0];

   // ---------------- stage 3: fold into half a turn, restore sign ----------------
   logic               s3_func_ff, s3_neg_ff;
   logic [15:0]        s3_rem_ff;
   logic               past_half;
   logic [14:0]        mag_in;
   logic signed [15:0] mag_s, err_in;

   always_ff @(posedge clock) begin
      if (r3 && v2_ff) begin
         s3_func_ff <= s2_func_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_rem_ff  <= rem_in;
      end
   end

   assign past_half = s3_rem_ff > 16'(HALF_TURN);
   assign mag_in    = past_half ? 15'(FULL_TURN - s3_rem_ff) : s3_rem_ff[14:0];
   assign mag_s     = signed'({1'b0, mag_in});
   // folding past half a turn flips the sign of the error
   assign err_in    = (s3_neg_ff ^ past_half) ? -mag_s : mag_s;

   // ---------------- stage 4: turn state ----------------
   logic               s4_func_ff;
   logic signed [15:0] s4_err_ff;
   logic [14:0]        s4_mag_ff;

   logic signed [23:0] sum_ff, sum_in, sum_sat;
   logic signed [24:0] sum_add;
   logic signed [15:0] prev_ff, prev_in;
   logic [15:0]        tick_ff, tick_in;
   logic               active_ff, active_in;
   term_type           term;

   always_ff @(posedge clock) begin
      if (r4 && v3_ff) begin
         s4_func_ff <= s3_func_ff;
         s4_err_ff  <= err_in;
         s4_mag_ff  <= mag_in;
      end
   end

   assign sum_add = 25'(sum_ff) + 25'(s4_err_ff);
   assign sum_sat = (sum_add[24] != sum_add[23]) ? (sum_add[24] ? SUM_MIN : SUM_MAX)
                                                 : sum_add[23:0];

   always_comb begin
      sum_in      = sum_ff;
      prev_in     = prev_ff;
      tick_in     = tick_ff;
      active_in   = active_ff;
      term.zero   = 1'b1;
      term.status = STATUS_IDLE;
      if (s4_func_ff == FUNC_START) begin
         // a start restarts the turn even while one is running
         sum_in      = '0;
         prev_in     = '0;
         tick_in     = '0;
         active_in   = 1'b1;
         term.status = STATUS_RUNNING;
      end else if (!active_ff) begin
         term.status = STATUS_IDLE;
      end else if (tick_ff >= timeout_ff) begin
         active_in   = 1'b0;
         term.status = STATUS_TIMEOUT;
      end else begin
         tick_in = tick_ff + 16'd1;
         prev_in = s4_err_ff;
         // integral runs only inside the zone, otherwise it is dropped
         sum_in  = (s4_mag_ff < zone_ff) ? sum_sat : 24'sd0;
         if (s4_mag_ff < settle_ff) begin
            active_in   = 1'b0;
            term.status = STATUS_SETTLED;
         end else begin
            term.zero   = 1'b0;
            term.status = STATUS_RUNNING;
         end
      end
      term.err   = s4_err_ff;
      term.sum   = sum_in;
      term.delta = 17'(s4_err_ff) - 17'(prev_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         prev_ff   <= '0;
         tick_ff   <= '0;
         active_ff <= 1'b0;
      end else if (fire4) begin
         sum_ff    <= sum_in;
         prev_ff   <= prev_in;
         tick_ff   <= tick_in;
         active_ff <= active_in;
      end
   end

   // ---------------- stages 5 to 9: drive back end ----------------
   logic signed [14:0] drive;
   status_type         status;

   htp_drive u_drive (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v4_ff),
      .in_ready   (r5),
      .in_term    (term),
      .gain_p     (gain_p_ff),
      .gain_i     (gain_i_ff),
      .gain_d     (gain_d_ff),
      .max_drive  (max_drive_ff),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_drive  (drive),
      .out_status (status)
   );

   assign rsp_tdata = {1'b0, drive};
   assign rsp_tuser = status;

endmodule

`default_nettype wire
